// ----- design/u8u2_pkg.sv -----
package u8u2_pkg;

    // Result status codes carried on the result tuser.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd2;

    // Continuation bytes still due in the back end.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // Queue depth and pointer width.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Byte class as seen without sequence context.
    typedef enum logic [1:0] {
        K_ASCII = 2'd0,
        K_LEAD2 = 2'd1,
        K_LEAD3 = 2'd2,
        K_OTHER = 2'd3
    } kind_t;

    // One classified byte on its way from the front end to the back end.
    typedef struct packed {
        kind_t      kind;
        logic [6:0] bits;
        logic       last;
    } item_t;

endpackage

// ----- design/u8u2_front.sv -----
module u8u2_front
    import u8u2_pkg::*;
(
    input  logic [7:0] byte_in,
    input  logic       last_in,
    output item_t      item
);

    // Classify the byte by its high bits; the low seven bits cover every payload.
    always_comb begin
        item.bits = byte_in[6:0];
        item.last = last_in;
        if (byte_in[7] == 1'b0) begin
            item.kind = K_ASCII;
        end else if (byte_in[7:4] == 4'b1110) begin
            item.kind = K_LEAD3;
        end else if (byte_in[7:5] == 3'b110) begin
            item.kind = K_LEAD2;
        end else begin
            item.kind = K_OTHER;
        end
    end

endmodule

// ----- design/u8u2_queue.sv -----
module u8u2_queue
    import u8u2_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  nonempty,
    output item_t head
);

    item_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/u8u2_back.sv -----
module u8u2_back
    import u8u2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_nonempty,
    input  item_t       q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_unit,
    output logic [1:0]  out_status,
    output logic        out_last
);

    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;
    logic [9:0]  partial_reg;
    logic [9:0]  partial_next;
    logic        valid_reg;
    logic        valid_next;
    logic [15:0] unit_reg;
    logic [15:0] unit_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic        last_reg;
    logic        last_next;
    logic        emit;
    logic        out_free;

    assign out_free   = !valid_reg || out_ready;
    assign q_pop      = q_nonempty && out_free;
    assign out_valid  = valid_reg;
    assign out_unit   = unit_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

    // Sequence state update and result formation for the item at the queue head.
    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        unit_next    = '0;
        status_next  = ST_OK;
        last_next    = q_head.last;
        unique case (pending_reg)
            PEND_NONE: begin
                unique case (q_head.kind)
                    K_ASCII: begin
                        emit      = 1'b1;
                        unit_next = {9'd0, q_head.bits};
                    end
                    K_LEAD3: begin
                        partial_next = {6'd0, q_head.bits[3:0]};
                        pending_next = PEND_TWO;
                    end
                    K_LEAD2: begin
                        partial_next = {5'd0, q_head.bits[4:0]};
                        pending_next = PEND_ONE;
                    end
                    default: begin
                        emit        = 1'b1;
                        status_next = ST_BAD_LEAD;
                    end
                endcase
            end
            PEND_ONE: begin
                emit         = 1'b1;
                unit_next    = {partial_reg, q_head.bits[5:0]};
                pending_next = PEND_NONE;
                partial_next = '0;
            end
            PEND_TWO: begin
                partial_next = {partial_reg[3:0], q_head.bits[5:0]};
                pending_next = PEND_ONE;
            end
            default: begin
                pending_next = PEND_NONE;
                partial_next = '0;
            end
        endcase

        // A final byte that leaves a sequence open reports truncation.
        if (!emit && q_head.last) begin
            emit         = 1'b1;
            unit_next    = '0;
            status_next  = ST_TRUNCATED;
            pending_next = PEND_NONE;
            partial_next = '0;
        end
    end

    // The output register holds a result until the sink takes it.
    always_comb begin
        valid_next = valid_reg && !out_ready;
        if (q_pop && emit) begin
            valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= PEND_NONE;
            partial_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (q_pop) begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            unit_reg   <= unit_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

endmodule

// ----- design/utf8_to_ucs2_decoder.sv -----
// UTF-8 to UCS-2 decoder. Bytes enter on the s_axis stream, one item per byte, with
// tlast marking the final byte of a buffer; 16-bit code units leave on the m_axis
// stream with a status in tuser (0 ok, 1 sequence truncated at a final byte, 2 invalid
// lead byte, code unit 0 on errors) and tlast on the result of a final byte. Two- and
// three-byte sequences are assembled; continuation bytes are not checked and give their
// low six bits. A byte that completes nothing and is not final gives no result. The
// block takes one byte every cycle while the queue is not full; the rate is set by the
// back end's sequence-state register, which updates once per byte. Each result passes a
// queue entry and the output register. A two-entry queue between the byte classifier and
// the back end lets either side stall alone; s_axis_tready drops only while it is full.
module utf8_to_ucs2_decoder
    import u8u2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    item_t front_item;
    item_t q_head;
    logic  q_full;
    logic  q_nonempty;
    logic  q_pop;
    logic  push;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    // Byte classification.
    u8u2_front u_front (
        .byte_in (s_axis_tdata),
        .last_in (s_axis_tlast),
        .item    (front_item)
    );

    // Decoupling queue.
    u8u2_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head      (q_head)
    );

    // Sequence assembly and result register.
    u8u2_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_unit   (m_axis_tdata),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    // Error results carry a zero code unit.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 16'd0))
        else $error("error result with nonzero code unit");

    // Truncation is only reported on the result of a final byte.
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_TRUNCATED) |-> m_axis_tlast)
        else $error("truncation without tlast");

    // The reserved status code is never produced.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_TRUNCATED
                           || m_axis_tuser == ST_BAD_LEAD))
        else $error("reserved status code");

    // Backpressure on the input means the queue holds items.
    a_full_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> q_nonempty)
        else $error("input stalled with empty queue");

endmodule

// ----- tb/sv/utf8_ucs2_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the decoder, predicts the code unit that each
// accepted byte should give and compares every accepted result with it.
module utf8_ucs2_checker
    import u8u2_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] code_unit
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          units_checked
);

    // One expected result item.
    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  status;
        logic        fin;
    } ucs2_result_t;

    ucs2_result_t want_q[$];

    // Our own copy of the sequence state.
    logic [1:0] seq_pending = PEND_NONE;
    logic [9:0] seq_bits    = '0;

    int err_n     = 0;
    int checked_n = 0;

    // Print one line per mismatch and count it; the log is capped so that a
    // badly broken design does not flood it.
    task automatic report_mismatch(input string msg);
        if (err_n < 40) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        err_n++;
    endtask

    task automatic push_want(input logic [15:0] unit, input logic [1:0] status,
                             input logic fin);
        ucs2_result_t r;
        r.unit   = unit;
        r.status = status;
        r.fin    = fin;
        want_q.push_back(r);
    endtask

    // Advance the sequence state by one byte and queue the result it causes.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic seq_open;
        seq_open = 1'b1;
        case (seq_pending)
            PEND_NONE: begin
                if (!b[7]) begin
                    push_want({8'h00, b}, ST_OK, fin);
                    seq_open = 1'b0;
                end else if (b[7:4] == 4'b1110) begin
                    seq_bits    = {6'd0, b[3:0]};
                    seq_pending = PEND_TWO;
                end else if (b[7:5] == 3'b110) begin
                    seq_bits    = {5'd0, b[4:0]};
                    seq_pending = PEND_ONE;
                end else begin
                    push_want(16'h0000, ST_BAD_LEAD, fin);
                    seq_open = 1'b0;
                end
            end
            PEND_ONE: begin
                // Last byte of a sequence: its low six bits close the unit.
                push_want({seq_bits, b[5:0]}, ST_OK, fin);
                seq_pending = PEND_NONE;
                seq_bits    = '0;
                seq_open    = 1'b0;
            end
            default: begin
                seq_bits    = {seq_bits[3:0], b[5:0]};
                seq_pending = PEND_ONE;
            end
        endcase
        // A final byte that leaves a sequence open truncates it.
        if (seq_open && fin) begin
            seq_pending = PEND_NONE;
            seq_bits    = '0;
            push_want(16'h0000, ST_TRUNCATED, 1'b1);
        end
    endtask

    // Results are checked before the byte of the same edge is predicted, since
    // a byte never gives its result in the cycle it is accepted.
    always @(posedge aclk) begin
        ucs2_result_t want;
        if (!aresetn) begin
            want_q.delete();
            seq_pending = PEND_NONE;
            seq_bits    = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (want_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result unit %h status %0d last %0b",
                                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
                end else begin
                    want = want_q.pop_front();
                    if (m_axis_tdata !== want.unit) begin
                        report_mismatch($sformatf("code unit %h, expected %h",
                                                  m_axis_tdata, want.unit));
                    end
                    if (m_axis_tuser !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser, want.status));
                    end
                    if (m_axis_tlast !== want.fin) begin
                        report_mismatch($sformatf("tlast %0b, expected %0b",
                                                  m_axis_tlast, want.fin));
                    end
                    checked_n++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
            end
        end
        mismatches    <= err_n;
        outstanding   <= want_q.size();
        units_checked <= checked_n;
    end

endmodule

// ----- tb/sv/tb_utf8_to_ucs2_decoder.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_ucs2_decoder;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] byte_in
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;            // [15:0] code_unit
    logic [1:0]  m_axis_tuser;            // [1:0] status
    logic        m_axis_tlast;

    int mismatches;
    int outstanding;
    int units_checked;

    // Pacing of both sides, in percent of cycles.
    int idle_pct  = 0;
    int stall_pct = 0;
    int idle_set[4]  = '{0, 51, 0, 15};
    int stall_set[4] = '{0, 0, 51, 15};

    // Long receiver hold-off, requested by the stimulus and timed below.
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    int bytes_sent  = 0;
    int finals_sent = 0;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } stream_byte_t;

    stream_byte_t stream_q[$];

    utf8_to_ucs2_decoder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_ucs2_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .units_checked (units_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= 80;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic add_byte(input logic [7:0] b, input logic fin);
        stream_byte_t sb;
        sb.b   = b;
        sb.fin = fin;
        stream_q.push_back(sb);
    endtask

    // Mostly a proper continuation byte, sometimes any byte at all.
    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom_range(255));
        if ($urandom_range(99) < 85) begin
            r[7:6] = 2'b10;
        end
        return r;
    endfunction

    // Mostly well-formed sequences with random content, plus invalid leads,
    // truncated sequences and raw noise bytes.
    task automatic add_random_bytes(input int n);
        int         target;
        int         pick;
        logic       fin;
        logic [7:0] r;
        target = stream_q.size() + n;
        while (stream_q.size() < target) begin
            pick = $urandom_range(99);
            fin  = ($urandom_range(99) < 8);
            r    = 8'($urandom_range(255));
            if (pick < 30) begin
                add_byte({1'b0, r[6:0]}, fin);
            end else if (pick < 55) begin
                add_byte({3'b110, r[4:0]}, 1'b0);
                add_byte(cont_byte(), fin);
            end else if (pick < 80) begin
                add_byte({4'b1110, r[3:0]}, 1'b0);
                add_byte(cont_byte(), 1'b0);
                add_byte(cont_byte(), fin);
            end else if (pick < 88) begin
                add_byte(r[6] ? {4'b1111, r[3:0]} : {2'b10, r[5:0]}, fin);
            end else if (pick < 94) begin
                if (r[7]) begin
                    add_byte({3'b110, r[4:0]}, 1'b1);
                end else if (r[6]) begin
                    add_byte({4'b1110, r[3:0]}, 1'b1);
                end else begin
                    add_byte({4'b1110, r[3:0]}, 1'b0);
                    add_byte(cont_byte(), 1'b1);
                end
            end else begin
                add_byte(r, fin);
            end
        end
    endtask

    // Offer one item, with random idle cycles before it, and wait for it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        bytes_sent++;
        if (fin) begin
            finals_sent++;
        end
    endtask

    task automatic send_stream();
        stream_byte_t sb;
        while (stream_q.size() != 0) begin
            sb = stream_q.pop_front();
            send_byte(sb.b, sb.fin);
        end
    endtask

    // Stop sending until every expected result has come, then let the
    // pipeline settle for bytes that gave no result.
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bytes: ASCII extremes, shortest and longest sequences.
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hDF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hE0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // Continuation bytes of any value only give their low six bits.
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hE1, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        // Invalid leads at both ends of both bad ranges, one of them final.
        add_byte(8'h80, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'hFF, 1'b1);
        // Final bytes that cut a sequence short, then a fresh stream.
        add_byte(8'hC5, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'hE3, 1'b1);
        add_byte(8'h41, 1'b1);
        add_byte(8'h7F, 1'b0);
        send_stream();
        wait_drained();

        // The receiver holds off for a long stretch while items keep coming.
        hold_req <= hold_req + 1;
        add_random_bytes(40);
        send_stream();
        wait_drained();

        // Random traffic under each pacing mix.
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            add_random_bytes(330);
            send_stream();
            wait_drained();
        end

        if (outstanding != 0) begin
            $display("%0d expected results never arrived", outstanding);
        end
        $display("Covered %0d bytes (%0d flagged final) under four pacing mixes and a hold-off;",
                 bytes_sent, finals_sent);
        $display("%0d result items were compared against the prediction.", units_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(300_000 * 12);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/u8u2_pkg.sv
design/u8u2_front.sv
design/u8u2_queue.sv
design/u8u2_back.sv
design/utf8_to_ucs2_decoder.sv
tb/sv/utf8_ucs2_checker.sv
tb/sv/tb_utf8_to_ucs2_decoder.sv
